[design/tsqi_pkg.sv]
// ----------------------------------------------------------------------------
// tsqi_pkg
// types and constants shared by the timestamped sample queue
// ----------------------------------------------------------------------------
package tsqi_pkg;

    localparam int SLOTS_DEF = 64;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_PEEK   = 2'd2,
        ACT_INTERP = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        sample_timestamp;
        logic signed [31:0] sample_position;
        logic               overwrite_if_full;
        logic [5:0]         peek_offset;
        logic [31:0]        query_timestamp;
    } t_in_item;

    typedef struct packed {
        logic               success;
        logic               dropped_oldest;
        logic [31:0]        result_timestamp;
        logic signed [31:0] result_position;
    } t_out_item;

endpackage

[design/tsqi_ram.sv]
// ----------------------------------------------------------------------------
// tsqi_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
module tsqi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[design/tsqi_div.sv]
// ----------------------------------------------------------------------------
// tsqi_div
// signed 64 by 33 bit restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module tsqi_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic [32:0]        i_den,
    output logic               o_done,
    output logic [31:0]        o_quot
);
    logic [63:0] r_q;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [33:0] n_trial;
    logic [33:0] n_shift;
    logic [63:0] n_qneg;

    assign n_shift = {r_rem[32:0], r_q[63]};
    assign n_trial = n_shift - {1'b0, r_den};
    assign n_qneg  = r_neg ? (~r_q + 64'd1) : r_q;
    assign o_quot  = n_qneg[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_rem  <= '0;
                r_den  <= i_den;
                r_neg  <= i_num[63];
                r_q    <= i_num[63] ? (~i_num + 64'd1) : i_num;
            end else if (r_busy) begin
                if (!n_trial[33]) begin
                    r_rem <= n_trial;
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

[design/timestamped_sample_queue_interp_unit.sv]
// ----------------------------------------------------------------------------
// timestamped_sample_queue_interp_unit
// ring fifo of timestamped samples with linear interpolation
// ----------------------------------------------------------------------------
// one command at a time: start is taken while busy is low, and exactly one
// result follows, shown on o_result for one cycle with o_done high; the
// receiver cannot stall it. a push answers on the cycle after it is taken and
// keeps busy low, so the next item can follow at once. a pop or peek that finds
// its sample holds busy through S_RD and S_RDW (one sample ram read). interpolate
// passes S_IW1, S_IRD1, S_IRD2 and S_IW2 for each discarded sample; with too few
// samples left it answers from S_IW1, and a blend goes on through S_IMUL and
// S_IDIV, waiting for the bit-serial 64-bit divider. busy stays high until the
// cycle that shows the result. samples live in one ram of SLOTS entries, one
// slot always left empty to tell full from empty
module timestamped_sample_queue_interp_unit #(
    parameter int SLOTS = tsqi_pkg::SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tsqi_pkg::t_in_item i_item,
    output logic               o_done,
    output tsqi_pkg::t_out_item o_result
);
    import tsqi_pkg::*;

    localparam int AW = $clog2(SLOTS);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDW, S_IRD1, S_IRD2, S_IW1, S_IW2, S_IMUL, S_IDIV
    } t_state;

    t_state           r_state;
    t_in_item         r_cmd;
    logic [AW-1:0]    r_wr, r_rd;
    logic [31:0]      r_t;
    logic [63:0]      r_e1;
    logic signed [63:0] r_m1, r_m2;
    logic [32:0]      r_d;

    // ram port signals
    logic             n_we;
    logic [AW-1:0]    n_waddr, n_raddr;
    logic [63:0]      n_wdata, w_rdata;
    logic             w_div_done, r_div_go;
    logic [31:0]      w_quot;

    // slot arithmetic modulo SLOTS
    function automatic logic [AW-1:0] f_add(input logic [AW-1:0] a, input logic [AW:0] b);
        logic [AW:0] s;
        begin
            s = {1'b0, a} + b;
            if (s >= SLOTS[AW:0]) s = s - SLOTS[AW:0];
            return s[AW-1:0];
        end
    endfunction

    logic [AW-1:0] w_cnt;
    logic          w_full;
    // queued samples: write slot minus read slot, modulo SLOTS
    assign w_cnt  = f_add(r_wr, (AW+1)'(SLOTS) - {1'b0, r_rd});
    assign w_full = (f_add(r_wr, (AW+1)'(1)) == r_rd);

    tsqi_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (n_we),
        .i_waddr(n_waddr),
        .i_wdata(n_wdata),
        .i_raddr(n_raddr),
        .o_rdata(w_rdata)
    );

    tsqi_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_go),
        .i_num  (r_m1 + r_m2),
        .i_den  (r_d),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    // push writes the ram straight from the incoming item
    always_comb begin
        n_we    = 1'b0;
        n_waddr = f_add(r_wr, (AW+1)'(1));
        n_wdata = {i_item.sample_timestamp, i_item.sample_position};
        n_raddr = f_add(r_rd, (AW+1)'(1));
        if (start && !busy && i_item.action == ACT_PUSH
            && (!w_full || i_item.overwrite_if_full)) begin
            n_we = 1'b1;
        end
        unique case (r_state)
            S_RD:   n_raddr = f_add(r_rd, (AW+1)'(1) +
                        (r_cmd.action == ACT_PEEK ? (AW+1)'(r_cmd.peek_offset) : '0));
            S_IRD1: n_raddr = f_add(r_rd, (AW+1)'(2));
            S_IRD2: n_raddr = f_add(r_rd, (AW+1)'(3));
            default: ;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    logic [31:0] w_t1, w_t2, w_tc;
    assign w_t1 = r_e1[63:32];
    assign w_t2 = w_rdata[63:32];
    assign w_tc = (r_t < w_t1) ? w_t1 : r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr     <= '0;
            r_rd     <= '0;
            o_done   <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            o_done   <= 1'b0;
            r_div_go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd <= i_item;
                        r_t   <= i_item.query_timestamp;
                        unique case (t_action'(i_item.action))
                            ACT_PUSH: begin
                                o_result <= '{
                                    success:          (!w_full || i_item.overwrite_if_full),
                                    dropped_oldest:   (w_full && i_item.overwrite_if_full),
                                    result_timestamp: 32'd0,
                                    result_position:  32'sd0
                                };
                                if (!w_full || i_item.overwrite_if_full) begin
                                    r_wr <= f_add(r_wr, (AW+1)'(1));
                                    if (w_full) r_rd <= f_add(r_rd, (AW+1)'(1));
                                end
                                o_done <= 1'b1;
                            end
                            ACT_POP: begin
                                o_result <= '0;
                                if (w_cnt == '0) o_done <= 1'b1;
                                else r_state <= S_RD;
                            end
                            ACT_PEEK: begin
                                o_result <= '0;
                                // needs offset+1 queued samples
                                if (32'(w_cnt) < 32'(i_item.peek_offset) + 32'd1)
                                    o_done <= 1'b1;
                                else r_state <= S_RD;
                            end
                            default: begin
                                o_result <= '0;
                                r_state  <= S_IW1;
                            end
                        endcase
                    end
                end
                S_RD:  r_state <= S_RDW;
                S_RDW: begin
                    o_result.success          <= 1'b1;
                    o_result.result_timestamp <= w_rdata[63:32];
                    o_result.result_position  <= w_rdata[31:0];
                    if (r_cmd.action == ACT_POP) r_rd <= f_add(r_rd, (AW+1)'(1));
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                // interpolate loop: check count, read entries 1 and 2
                S_IW1: begin
                    if (w_cnt < AW'(4)) begin
                        o_result.result_timestamp <= r_t;
                        o_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_IRD1;
                    end
                end
                S_IRD1: r_state <= S_IRD2;
                S_IRD2: begin
                    r_e1    <= w_rdata;
                    r_state <= S_IW2;
                end
                S_IW2: begin
                    r_t <= w_tc;
                    if (w_tc < w_t2) begin
                        r_m1 <= $signed({1'b0, w_t2 - w_tc}) * $signed(r_e1[31:0]);
                        r_m2 <= $signed({1'b0, w_tc - w_t1}) * $signed(w_rdata[31:0]);
                        r_d  <= {1'b0, w_t2 - w_t1};
                        r_state <= S_IMUL;
                    end else begin
                        r_rd    <= f_add(r_rd, (AW+1)'(1));
                        r_state <= S_IW1;
                    end
                end
                S_IMUL: begin
                    r_div_go <= 1'b1;
                    r_state  <= S_IDIV;
                end
                S_IDIV: begin
                    if (w_div_done) begin
                        o_result.success          <= 1'b1;
                        o_result.result_timestamp <= r_t;
                        o_result.result_position  <= w_quot;
                        o_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[test/tb_timestamped_sample_queue_interp_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamped_sample_queue_interp_unit
// self-checking bench for the timestamped sample queue with interpolation
// ----------------------------------------------------------------------------
// a built-in queue predictor tracks the ring indexes and sample slots and
// computes the result of every accepted command item. a checker compares each
// o_done result, field by field, with the oldest pending prediction. directed
// tests cover empty, full, peek range and interpolation corners; random
// phases then push mostly time-ordered samples mixed with pops, peeks and
// interpolation queries, with sender gaps of several densities
// ----------------------------------------------------------------------------
module tb_timestamped_sample_queue_interp_unit;
    import tsqi_pkg::*;

    localparam int    RING       = SLOTS_DEF;
    localparam int    DRAIN_WAIT = 400;      // longer than the worst interpolate
    localparam longint CYCLE_CAP = 1500000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_done;
    t_out_item o_result;

    timestamped_sample_queue_interp_unit #(.SLOTS(RING)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // predictor state: slot of newest sample, slot just before oldest
    logic [5:0]  newest_slot;
    logic [5:0]  oldest_prev_slot;
    logic [63:0] sample_slots [RING];

    t_out_item pending_results[$];
    bit        failed;
    int        sender_idle_pct;
    logic [31:0] ts_clock;   // running timestamp for well-formed sample streams
    longint    cycle_count;

    // ------------------------------------------------------------------------
    // queue predictor: applies one command item, returns the expected result
    // ------------------------------------------------------------------------
    function automatic t_out_item predict_queue(t_in_item it);
        t_out_item   r;
        logic [5:0]  depth;
        logic [63:0] e1;
        logic [63:0] e2;
        logic [31:0] t;
        logic [31:0] t1;
        logic [31:0] t2;
        longint      num;
        longint      den;
        longint      quo;
        r = '0;
        depth = newest_slot - oldest_prev_slot;
        case (t_action'(it.action))
            ACT_PUSH: begin
                // full when one free slot remains
                if (newest_slot + 6'd1 != oldest_prev_slot || it.overwrite_if_full) begin
                    if (newest_slot + 6'd1 == oldest_prev_slot) begin
                        oldest_prev_slot = oldest_prev_slot + 6'd1;
                        r.dropped_oldest = 1'b1;
                    end
                    newest_slot = newest_slot + 6'd1;
                    sample_slots[newest_slot] = {it.sample_timestamp, it.sample_position};
                    r.success = 1'b1;
                end
            end
            ACT_POP: begin
                if (depth != 0) begin
                    e1 = sample_slots[6'(oldest_prev_slot + 6'd1)];
                    oldest_prev_slot = oldest_prev_slot + 6'd1;
                    r.success = 1'b1;
                    r.result_timestamp = e1[63:32];
                    r.result_position  = e1[31:0];
                end
            end
            ACT_PEEK: begin
                // needs offset+1 queued samples
                if (7'(depth) >= 7'(it.peek_offset) + 7'd1) begin
                    e1 = sample_slots[6'(oldest_prev_slot + 6'd1 + it.peek_offset)];
                    r.success = 1'b1;
                    r.result_timestamp = e1[63:32];
                    r.result_position  = e1[31:0];
                end
            end
            default: begin
                t = it.query_timestamp;
                while (6'(newest_slot - oldest_prev_slot) >= 6'd4) begin
                    e1 = sample_slots[6'(oldest_prev_slot + 6'd2)];
                    e2 = sample_slots[6'(oldest_prev_slot + 6'd3)];
                    t1 = e1[63:32];
                    t2 = e2[63:32];
                    if (t < t1) t = t1;
                    if (t < t2) begin
                        // exact 64-bit blend, truncating toward zero
                        num = longint'({32'd0, t2 - t}) * longint'(signed'(e1[31:0]))
                            + longint'({32'd0, t - t1}) * longint'(signed'(e2[31:0]));
                        den = longint'({32'd0, t2 - t1});
                        quo = num / den;
                        r.success = 1'b1;
                        r.result_position = quo[31:0];
                        break;
                    end
                    oldest_prev_slot = oldest_prev_slot + 6'd1;
                end
                r.result_timestamp = t;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checker: every o_done must match the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h, none pending", $time, o_result);
                failed = 1'b1;
            end else begin
                t_out_item exp_r;
                exp_r = pending_results.pop_front();
                if (o_result.success !== exp_r.success) begin
                    $display("%0t: success exp %0b act %0b", $time,
                             exp_r.success, o_result.success);
                    failed = 1'b1;
                end
                if (o_result.dropped_oldest !== exp_r.dropped_oldest) begin
                    $display("%0t: dropped_oldest exp %0b act %0b", $time,
                             exp_r.dropped_oldest, o_result.dropped_oldest);
                    failed = 1'b1;
                end
                if (o_result.result_timestamp !== exp_r.result_timestamp) begin
                    $display("%0t: result_timestamp exp %h act %h", $time,
                             exp_r.result_timestamp, o_result.result_timestamp);
                    failed = 1'b1;
                end
                if (o_result.result_position !== exp_r.result_position) begin
                    $display("%0t: result_position exp %h act %h", $time,
                             exp_r.result_position, o_result.result_position);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // item driver: optional random gap, then hold start until accepted
    // ------------------------------------------------------------------------
    task automatic send_item(t_in_item it);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_item <= it;
        start  <= 1'b1;
        // busy is settled at the falling edge before the accepting edge
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_results.push_back(predict_queue(it));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_item mk_item(t_action act, logic [31:0] ts,
                                         logic [31:0] pos, logic ovw,
                                         logic [5:0] offs, logic [31:0] q);
        t_in_item it;
        it.action            = act;
        it.sample_timestamp  = ts;
        it.sample_position   = pos;
        it.overwrite_if_full = ovw;
        it.peek_offset       = offs;
        it.query_timestamp   = q;
        return it;
    endfunction

    // random item of the given action, every bit of every other field exercised
    function automatic t_in_item noise_item(t_action act);
        t_in_item it;
        it = mk_item(act, $urandom, $urandom, 1'($urandom), 6'($urandom), $urandom);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------------
    task automatic test_empty_queue();
        send_item(noise_item(ACT_POP));
        send_item(mk_item(ACT_PEEK, '1, '1, 1'b1, 6'd0, '1));
        send_item(mk_item(ACT_INTERP, 0, 0, 1'b0, 6'd0, 32'hffff_ffff));
        send_item(mk_item(ACT_PUSH, 32'hffff_ffff, 32'h8000_0000, 1'b0, 6'd63, 0));
        send_item(mk_item(ACT_PUSH, 32'd0, 32'h7fff_ffff, 1'b1, 6'd0, 0));
        // too few samples for a blend
        send_item(mk_item(ACT_INTERP, 0, 0, 1'b0, 6'd0, 32'd5));
        send_item(mk_item(ACT_POP, 0, 0, 1'b0, 6'd0, 0));
        send_item(mk_item(ACT_POP, 0, 0, 1'b0, 6'd0, 0));
    endtask

    task automatic test_full_queue();
        // fill to 63, then refused and overwriting pushes
        for (int k = 0; k < RING - 1; k++)
            send_item(mk_item(ACT_PUSH, 32'(k * 10), $urandom, 1'b0, 6'd0, 32'd0));
        send_item(mk_item(ACT_PUSH, 32'd999, 32'h1234_5678, 1'b0, 6'd0, 0));
        send_item(mk_item(ACT_PUSH, 32'd1000, 32'h8765_4321, 1'b1, 6'd0, 0));
    endtask

    task automatic test_peek_range();
        send_item(mk_item(ACT_PEEK, 0, 0, 1'b0, 6'd62, 0));
        send_item(mk_item(ACT_PEEK, 0, 0, 1'b0, 6'd63, 0));
        send_item(mk_item(ACT_PEEK, 0, 0, 1'b0, 6'd0, 0));
        send_item(mk_item(ACT_POP, 0, 0, 1'b0, 6'd0, 0));
        send_item(mk_item(ACT_PEEK, 0, 0, 1'b0, 6'd62, 0));
        send_item(mk_item(ACT_PEEK, 0, 0, 1'b0, 6'd61, 0));
    endtask

    task automatic test_interp_corners();
        // empty the queue, then load extreme span and positions
        while (newest_slot != oldest_prev_slot)
            send_item(mk_item(ACT_POP, 0, 0, 1'b0, 6'd0, 0));
        send_item(mk_item(ACT_PUSH, 32'd0, 32'd0, 1'b0, 6'd0, 0));
        send_item(mk_item(ACT_PUSH, 32'd0, 32'h8000_0000, 1'b0, 6'd0, 0));
        send_item(mk_item(ACT_PUSH, 32'hffff_ffff, 32'h7fff_ffff, 1'b0, 6'd0, 0));
        send_item(mk_item(ACT_PUSH, 32'hffff_ffff, 32'h8000_0000, 1'b0, 6'd0, 0));
        // query at the lower sample, midpoint, just below the upper sample
        send_item(mk_item(ACT_INTERP, 0, 0, 1'b0, 6'd0, 32'd0));
        send_item(mk_item(ACT_INTERP, 0, 0, 1'b0, 6'd0, 32'h7fff_ffff));
        send_item(mk_item(ACT_INTERP, 0, 0, 1'b0, 6'd0, 32'hffff_fffe));
        // at the upper sample: pops until too few remain
        send_item(mk_item(ACT_INTERP, 0, 0, 1'b0, 6'd0, 32'hffff_ffff));
        while (newest_slot != oldest_prev_slot)
            send_item(mk_item(ACT_POP, 0, 0, 1'b0, 6'd0, 0));
        ts_clock = 0;
    endtask

    // ------------------------------------------------------------------------
    // random phase: mostly time-ordered pushes mixed with pops, peeks and interpolation queries
    // ------------------------------------------------------------------------
    task automatic test_random_traffic(int n_items, int idle_pct);
        t_in_item it;
        int       pick;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                it = noise_item(ACT_PUSH);
                if ($urandom_range(19) != 0) begin
                    // occasional equal timestamps, sometimes big jumps
                    ts_clock = ts_clock + ($urandom_range(9) == 0 ?
                               $urandom_range(0, 1000000) : $urandom_range(0, 40));
                    it.sample_timestamp = ts_clock;
                end
                // keep depth shallow most of the time so queries see data
                if (6'(newest_slot - oldest_prev_slot) > 12 && $urandom_range(3) != 0)
                    it.action = ACT_POP;
            end else if (pick < 57) begin
                it = noise_item(ACT_POP);
            end else if (pick < 70) begin
                it = noise_item(ACT_PEEK);
                if ($urandom_range(3) != 0)
                    it.peek_offset = 6'($urandom_range(0, 15));
            end else begin
                it = noise_item(ACT_INTERP);
                if ($urandom_range(4) != 0)
                    it.query_timestamp = ts_clock - $urandom_range(0, 150);
            end
            send_item(it);
        end
    endtask

    initial begin
        failed          = 1'b0;
        cycle_count     = 0;
        sender_idle_pct = 24;
        ts_clock        = 0;
        newest_slot      = '0;
        oldest_prev_slot = '0;
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_full_queue();
        test_peek_range();
        test_interp_corners();
        test_random_traffic(400, 24);
        // hold off until everything is back
        wait_drained();
        test_random_traffic(400, 53);
        test_random_traffic(400, 0);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (!failed && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
design/tsqi_pkg.sv
design/tsqi_ram.sv
design/tsqi_div.sv
design/timestamped_sample_queue_interp_unit.sv
test/tb_timestamped_sample_queue_interp_unit.sv
